FILE: rtl/rwlq_pkg.sv
// ============================================================================
// rwlq_pkg: shared constants and types for the rolling window level quantizer
// Window geometry, field widths, opcodes and the controller/datapath bundles.
// ============================================================================
`default_nettype none

package rwlq_pkg;

    localparam int HIST_DEPTH  = 32;
    localparam int IDX_W       = $clog2(HIST_DEPTH);
    localparam int MAX_RESULTS = 32;
    localparam int CNT_CAP     = (HIST_DEPTH < MAX_RESULTS) ? HIST_DEPTH : MAX_RESULTS;
    localparam int CNT_W       = 6;

    localparam int SAMPLE_W  = 32;
    localparam int LIMIT_W   = 6;
    localparam int LEVEL_W   = 3;
    localparam int PROD_W    = SAMPLE_W + LEVEL_W;   // sample * 7 never overflows
    localparam int DSTEP_W   = 2;
    localparam int S_TDATA_W = 40;                   // sample + glyph_limit, byte padded
    localparam int M_TDATA_W = 8;                    // level, byte padded

    localparam logic MODE_PUSH   = 1'b0;
    localparam logic MODE_RENDER = 1'b1;

    // Controller -> datapath commands
    typedef struct packed {
        logic push;
        logic render_ld;
        logic idx_clr;
        logic idx_inc;
        logic rd_scan;
        logic rd_emit;
        logic max_upd;
        logic div_load;
        logic div_step;
        logic out_load;
    } rwlq_cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic mode;
        logic cnt_zero;
        logic idx_last_scan;
        logic idx_last_emit;
        logic div_done;
        logic out_free;
    } rwlq_stat_t;

endpackage

`default_nettype wire

FILE: rtl/rwlq_dp.sv
// ============================================================================
// rwlq_dp: datapath of the rolling window level quantizer
// Sample ring with valid bits, head pointer, max tracker, restoring divider
// for the 3-bit level and the output register.
// ============================================================================
`default_nettype none

module rwlq_dp (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tuser,
    input  wire [rwlq_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [rwlq_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tlast,
    input  rwlq_pkg::rwlq_cmd_t              cmd,
    output rwlq_pkg::rwlq_stat_t             stat
);

    logic [rwlq_pkg::SAMPLE_W-1:0] mem [rwlq_pkg::HIST_DEPTH];
    logic [rwlq_pkg::HIST_DEPTH-1:0] vld_reg;
    logic [rwlq_pkg::IDX_W-1:0]      head_reg;
    logic [rwlq_pkg::CNT_W-1:0]      idx_reg;
    logic [rwlq_pkg::CNT_W-1:0]      cnt_reg;
    logic [rwlq_pkg::SAMPLE_W-1:0]   rd_data_reg;
    logic                            rd_vld_reg;
    logic [rwlq_pkg::SAMPLE_W-1:0]   max_reg;
    logic [rwlq_pkg::PROD_W-1:0]     rem_reg;
    logic [rwlq_pkg::LEVEL_W-1:0]    quo_reg;
    logic [rwlq_pkg::DSTEP_W-1:0]    dstep_reg;
    logic                            out_vld_reg;
    logic [rwlq_pkg::LEVEL_W-1:0]    lvl_reg;
    logic                            last_reg;

    logic [rwlq_pkg::SAMPLE_W-1:0]   in_sample;
    logic [rwlq_pkg::LIMIT_W-1:0]    in_limit;
    logic [rwlq_pkg::IDX_W:0]        emit_sum;
    logic [rwlq_pkg::IDX_W-1:0]      emit_addr;
    logic [rwlq_pkg::IDX_W-1:0]      rd_addr;
    logic [rwlq_pkg::SAMPLE_W-1:0]   rd_word;
    logic [rwlq_pkg::PROD_W-1:0]     prod7;
    logic [rwlq_pkg::PROD_W-1:0]     div_trial;

    assign in_sample = s_tdata[rwlq_pkg::SAMPLE_W-1:0];
    assign in_limit  = s_tdata[rwlq_pkg::SAMPLE_W +: rwlq_pkg::LIMIT_W];

    // oldest-first walk: head + idx, wrapped at the window depth
    assign emit_sum  = {1'b0, head_reg} + {1'b0, idx_reg[rwlq_pkg::IDX_W-1:0]};
    assign emit_addr = (emit_sum >= (rwlq_pkg::IDX_W+1)'(rwlq_pkg::HIST_DEPTH))
                     ? rwlq_pkg::IDX_W'(emit_sum - (rwlq_pkg::IDX_W+1)'(rwlq_pkg::HIST_DEPTH))
                     : emit_sum[rwlq_pkg::IDX_W-1:0];
    assign rd_addr   = cmd.rd_emit ? emit_addr : idx_reg[rwlq_pkg::IDX_W-1:0];

    // never-written entries read as zero
    assign rd_word   = rd_vld_reg ? rd_data_reg : '0;
    assign prod7     = ({{rwlq_pkg::LEVEL_W{1'b0}}, rd_word} << 3)
                     - {{rwlq_pkg::LEVEL_W{1'b0}}, rd_word};
    assign div_trial = {{rwlq_pkg::LEVEL_W{1'b0}}, max_reg} << dstep_reg;

    // sample storage, no reset
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            mem[head_reg] <= in_sample;
        end
        if (cmd.rd_scan || cmd.rd_emit) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            head_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (cmd.push) begin
                vld_reg[head_reg] <= 1'b1;
                head_reg <= (head_reg == rwlq_pkg::IDX_W'(rwlq_pkg::HIST_DEPTH - 1))
                          ? '0 : head_reg + 1'b1;
            end
            if (cmd.rd_scan || cmd.rd_emit) begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
            if (cmd.out_load) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.render_ld) begin
            cnt_reg <= (in_limit > rwlq_pkg::LIMIT_W'(rwlq_pkg::CNT_CAP))
                     ? rwlq_pkg::CNT_W'(rwlq_pkg::CNT_CAP) : rwlq_pkg::CNT_W'(in_limit);
            max_reg <= rwlq_pkg::SAMPLE_W'(1);
        end else if (cmd.max_upd && (rd_word > max_reg)) begin
            max_reg <= rd_word;
        end

        if (cmd.idx_clr) begin
            idx_reg <= '0;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_reg + 1'b1;
        end

        // restoring division of 7*sample by max, one quotient bit per step
        if (cmd.div_load) begin
            rem_reg   <= prod7;
            quo_reg   <= '0;
            dstep_reg <= rwlq_pkg::DSTEP_W'(rwlq_pkg::LEVEL_W - 1);
        end else if (cmd.div_step) begin
            if (rem_reg >= div_trial) begin
                rem_reg            <= rem_reg - div_trial;
                quo_reg[dstep_reg] <= 1'b1;
            end
            dstep_reg <= dstep_reg - 1'b1;
        end

        if (cmd.out_load) begin
            lvl_reg  <= quo_reg;
            last_reg <= stat.idx_last_emit;
        end
    end

    assign stat.mode          = s_tuser;
    assign stat.cnt_zero      = (in_limit == '0);
    assign stat.idx_last_scan = (idx_reg == rwlq_pkg::CNT_W'(rwlq_pkg::HIST_DEPTH - 1));
    assign stat.idx_last_emit = ((idx_reg + 1'b1) == cnt_reg);
    assign stat.div_done      = (dstep_reg == '0);
    assign stat.out_free      = !out_vld_reg || m_tready;

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(rwlq_pkg::M_TDATA_W - rwlq_pkg::LEVEL_W){1'b0}}, lvl_reg};
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

FILE: rtl/rwlq_ctrl.sv
// ============================================================================
// rwlq_ctrl: controller of the rolling window level quantizer
// Sequences push, window max scan, per-entry divide and result hand-off.
// ============================================================================
`default_nettype none

module rwlq_ctrl (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_tvalid,
    output logic                  s_tready,
    input  rwlq_pkg::rwlq_stat_t  stat,
    output rwlq_pkg::rwlq_cmd_t   cmd
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SCAN     = 3'd1;
    localparam logic [2:0] ST_SCAN_END = 3'd2;
    localparam logic [2:0] ST_EMIT_RD  = 3'd3;
    localparam logic [2:0] ST_DIV_LD   = 3'd4;
    localparam logic [2:0] ST_DIV_RUN  = 3'd5;
    localparam logic [2:0] ST_EMIT_OUT = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       rd_pend_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rd_pend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_pend_reg <= (state_reg == ST_SCAN);
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (stat.mode == rwlq_pkg::MODE_PUSH) begin
                        cmd.push = 1'b1;
                    end else if (!stat.cnt_zero) begin
                        cmd.render_ld = 1'b1;
                        cmd.idx_clr   = 1'b1;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                cmd.rd_scan = 1'b1;
                cmd.idx_inc = 1'b1;
                cmd.max_upd = rd_pend_reg;
                if (stat.idx_last_scan) begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END: begin
                cmd.max_upd = 1'b1;
                cmd.idx_clr = 1'b1;
                state_next  = ST_EMIT_RD;
            end
            ST_EMIT_RD: begin
                cmd.rd_emit = 1'b1;
                state_next  = ST_DIV_LD;
            end
            ST_DIV_LD: begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIV_RUN;
            end
            ST_DIV_RUN: begin
                cmd.div_step = 1'b1;
                if (stat.div_done) begin
                    state_next = ST_EMIT_OUT;
                end
            end
            ST_EMIT_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    if (stat.idx_last_emit) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/rolling_window_level_quantizer.sv
// ============================================================================
// rolling_window_level_quantizer: sparkline level generator
// Ring of recent throughput samples rendered as 0..7 bar levels on request.
// ============================================================================
// A push transaction (s_tuser = 0) stores s_tdata[31:0] at the ring head.
// A render transaction (s_tuser = 1) scans all HIST_DEPTH entries for the
// maximum (floor of 1), then emits min(glyph_limit, 32) levels, oldest
// first, each floor(sample*7/max), with m_tlast on the final one; a limit
// of 0 emits nothing. The scan reads the sample memory one entry per cycle
// through its single read port, and each level needs a memory read, a load
// and three restoring-divide steps before it enters the output register,
// where output backpressure can hold it. Entries never pushed read as zero
// via per-entry valid bits cleared at reset, so no clearing pass is needed.
// ============================================================================
`default_nettype none

module rolling_window_level_quantizer (
    input  wire                               aclk,
    input  wire                               aresetn,
    // input transactions
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire [rwlq_pkg::S_TDATA_W-1:0]     s_tdata,   // [31:0] sample, [37:32] glyph_limit
    input  wire                               s_tuser,   // [0] mode: 0 push, 1 render
    // level transactions
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [rwlq_pkg::M_TDATA_W-1:0]    m_tdata,   // [2:0] level
    output logic                              m_tlast    // final level of a render
);

    rwlq_pkg::rwlq_cmd_t  cmd;
    rwlq_pkg::rwlq_stat_t stat;

    // sequencing: push, max scan, per-level divide and hand-off
    rwlq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // storage, max tracker, divider and output register
    rwlq_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

`default_nettype wire
